// ===== sv/itt_pkg.sv =====
`default_nettype none
package itt_pkg;

	localparam int DEF_TIMER_SLOTS = 16;
	localparam int DEF_COUNT_BITS  = 32;

	localparam int PERIOD_W   = 32;
	localparam int SLOT_IDX_W = 4;
	localparam int KIND_W     = 2;
	localparam int STEP_W     = 10;

	localparam logic [STEP_W-1:0] STEP_RESET = 10'd1;

	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIRE,
		ST_FLUSH
	} seq_state_t;

	typedef enum logic {
		UM_START,
		UM_FIRE
	} unit_mode_t;

	typedef struct packed {
		logic armed;
		logic expire;
	} slot_flags_t;

endpackage
`default_nettype wire

// ===== sv/interval_timeout_timer_bank.sv =====
`default_nettype none
// Bank of timer slots on a tick counter that each tick item advances by the
// configured step. Start and stop items are taken without raising busy. A
// tick item holds busy while the slot memory, which has one read port, is
// walked: once to find the earliest reached deadline, and when one is reached,
// once more to fire and reschedule that group, followed by the flush state.
// Results of a tick come out during the second walk, at most one per cycle,
// each on strobe for exactly one cycle; the final one, with last set, comes
// in the first cycle after busy drops. The receiver cannot stall them, so it
// must take every strobe. A tick that fires nothing gives no result.
module interval_timeout_timer_bank
	import itt_pkg::*;
#(
	parameter int TIMER_SLOTS = DEF_TIMER_SLOTS,
	parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [STEP_W-1:0]     cfg_wdata,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [KIND_W-1:0]     kind,
	input  wire logic [SLOT_IDX_W-1:0] slot_index,
	input  wire logic [PERIOD_W-1:0]   period,
	input  wire logic [PERIOD_W-1:0]   total_timeout,
	input  wire logic                  single_shot,
	output logic                       strobe,
	output logic [SLOT_IDX_W-1:0]      fired_slot,
	output logic                       event_type,
	output logic                       last
);

	localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int REC_W  = 2 * PERIOD_W + COUNT_BITS + 1;
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TIMER_SLOTS - 1);

	seq_state_t state_q, state_d;

	logic [STEP_W-1:0]      tick_step_q;
	logic [COUNT_BITS-1:0]  counter_q;
	logic [TIMER_SLOTS-1:0] armed_q;

	logic              issue_q;
	logic [SLOT_W-1:0] rd_addr_q;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;

	logic                  found_q;
	logic [COUNT_BITS-1:0] best_diff_q;
	logic [COUNT_BITS-1:0] best_dl_q;

	logic              pend_v_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic              pend_ev_q;

	logic seq_start, advance, pass_end;
	logic accept, slot_ok, scan_hit, fire_hit, found_nxt;

	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic [REC_W-1:0]  wr_data;
	logic [REC_W-1:0]  rd_data;

	logic [PERIOD_W-1:0]   rd_per, rd_rem;
	logic [COUNT_BITS-1:0] rd_dl;
	logic                  rd_once;

	unit_mode_t            u_mode;
	logic [PERIOD_W-1:0]   u_per, u_rem_in, u_rem;
	logic                  u_once;
	logic [COUNT_BITS-1:0] u_diff, u_dl;
	slot_flags_t           u_flags;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign slot_ok = (32'(slot_index) < 32'(TIMER_SLOTS));

	assign rd_per  = rd_data[REC_W-1 -: PERIOD_W];
	assign rd_rem  = rd_data[1 + COUNT_BITS +: PERIOD_W];
	assign rd_dl   = rd_data[1 +: COUNT_BITS];
	assign rd_once = rd_data[0];

	itt_slot_ram #(
		.DEPTH  (TIMER_SLOTS),
		.ADDR_W (SLOT_W),
		.WIDTH  (REC_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	always_comb begin
		if (state_q == ST_IDLE) begin
			u_mode   = UM_START;
			u_per    = period;
			u_rem_in = total_timeout;
			u_once   = single_shot;
		end else begin
			u_mode   = UM_FIRE;
			u_per    = rd_per;
			u_rem_in = rd_rem;
			u_once   = rd_once;
		end
	end

	itt_slot_unit #(
		.COUNT_BITS (COUNT_BITS)
	) u_unit (
		.mode         (u_mode),
		.counter      (counter_q),
		.per          (u_per),
		.rem          (u_rem_in),
		.deadline     (rd_dl),
		.once         (u_once),
		.diff         (u_diff),
		.new_deadline (u_dl),
		.new_rem      (u_rem),
		.flags        (u_flags)
	);

	assign pass_end = vld_s1 && (idx_s1 == LAST_IDX);

	// reached when the wrap-safe difference has its top bit clear
	assign scan_hit = vld_s1 && (state_q == ST_SCAN) && armed_q[idx_s1]
		&& !u_diff[COUNT_BITS-1] && (!found_q || (u_diff > best_diff_q));
	assign fire_hit = vld_s1 && (state_q == ST_FIRE) && armed_q[idx_s1]
		&& (rd_dl == best_dl_q);
	assign found_nxt = found_q || scan_hit;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = {rd_per, u_rem, u_dl, rd_once};
		if (accept && (kind == KIND_START) && slot_ok) begin
			wr_en   = 1'b1;
			wr_addr = SLOT_W'(slot_index);
			wr_data = {period, u_rem, u_dl, single_shot};
		end else if (fire_hit) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		state_d   = state_q;
		seq_start = 1'b0;
		advance   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (kind == KIND_TICK)) begin
					state_d   = ST_SCAN;
					seq_start = 1'b1;
				end
			end
			ST_SCAN: begin
				if (pass_end) begin
					if (found_nxt) begin
						state_d   = ST_FIRE;
						seq_start = 1'b1;
					end else begin
						state_d = ST_IDLE;
						advance = 1'b1;
					end
				end
			end
			ST_FIRE: begin
				if (pass_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				advance = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q <= STEP_RESET;
			counter_q   <= '0;
			armed_q     <= '0;
			issue_q     <= 1'b0;
			rd_addr_q   <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			strobe      <= 1'b0;
		end else begin
			if (cfg_we) begin
				tick_step_q <= cfg_wdata;
			end
			if (advance) begin
				counter_q <= counter_q + COUNT_BITS'(tick_step_q);
			end

			if (accept && slot_ok) begin
				if (kind == KIND_START) begin
					armed_q[SLOT_W'(slot_index)] <= u_flags.armed;
				end else if (kind == KIND_STOP) begin
					armed_q[SLOT_W'(slot_index)] <= 1'b0;
				end
			end
			if (fire_hit) begin
				armed_q[idx_s1] <= u_flags.armed;
			end

			// walk the slot memory, read data lands in the cycle after its address
			if (seq_start) begin
				rd_addr_q <= '0;
				issue_q   <= 1'b1;
			end else if (issue_q) begin
				if (rd_addr_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					rd_addr_q <= rd_addr_q + SLOT_W'(1);
				end
			end
			vld_s1 <= issue_q;
			idx_s1 <= rd_addr_q;

			if (seq_start && (state_q == ST_IDLE)) begin
				found_q <= 1'b0;
			end else if (scan_hit) begin
				found_q <= 1'b1;
			end

			// hold one result back so the final one can carry last
			strobe <= (fire_hit && pend_v_q) || (state_q == ST_FLUSH);
			if (fire_hit) begin
				pend_v_q <= 1'b1;
			end else if (state_q == ST_FLUSH) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_hit) begin
			best_diff_q <= u_diff;
			best_dl_q   <= rd_dl;
		end
		if (fire_hit) begin
			pend_slot_q <= idx_s1;
			pend_ev_q   <= u_flags.expire;
		end
		fired_slot <= SLOT_IDX_W'(pend_slot_q);
		event_type <= pend_ev_q;
		last       <= (state_q == ST_FLUSH);
	end

endmodule
`default_nettype wire

// ===== sv/itt_slot_ram.sv =====
`default_nettype none
module itt_slot_ram #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int WIDTH  = 97
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== sv/itt_slot_unit.sv =====
`default_nettype none
module itt_slot_unit
	import itt_pkg::*;
#(
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire unit_mode_t            mode,
	input  wire logic [COUNT_BITS-1:0] counter,
	input  wire logic [PERIOD_W-1:0]   per,
	input  wire logic [PERIOD_W-1:0]   rem,
	input  wire logic [COUNT_BITS-1:0] deadline,
	input  wire logic                  once,
	output logic      [COUNT_BITS-1:0] diff,
	output logic      [COUNT_BITS-1:0] new_deadline,
	output logic      [PERIOD_W-1:0]   new_rem,
	output slot_flags_t                flags
);

	localparam int SUM_W = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;

	logic [PERIOD_W-1:0] rem_left;
	logic [PERIOD_W-1:0] r_arm;
	logic [PERIOD_W-1:0] addend;
	logic [SUM_W-1:0]    sum;
	logic                expire;
	logic                arm_cond;
	logic                resched_once;

	assign diff = counter - deadline;

	always_comb begin
		expire       = (per == '0) || (rem < per);
		rem_left     = rem - per;
		r_arm        = (mode == UM_START) ? rem : rem_left;
		arm_cond     = (per != '0) && (per < r_arm);
		resched_once = (mode == UM_FIRE) && once;

		// single-shot reschedules for the whole rest, periodic uses the start rule
		if (resched_once) begin
			addend  = r_arm;
			new_rem = '0;
		end else begin
			addend  = arm_cond ? per : r_arm;
			new_rem = arm_cond ? r_arm : '0;
		end

		sum          = SUM_W'(counter) + SUM_W'(addend);
		new_deadline = sum[COUNT_BITS-1:0];

		flags.expire = (mode == UM_FIRE) && expire;
		if (mode == UM_START) begin
			flags.armed = (r_arm != '0);
		end else if (expire) begin
			flags.armed = 1'b0;
		end else begin
			flags.armed = once || (r_arm != '0);
		end
	end

endmodule
`default_nettype wire
